/* rtl/core/schr_pkg.sv */
`timescale 1ns / 1ps
package schr_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned CELL_W  = 31;
	localparam int unsigned KEY_W   = 28;
	localparam int unsigned HW_W    = 29;
	localparam logic [HW_W-1:0] HW_RESET = 29'd261120;
	localparam logic signed [33:0] CELL_MAX = 34'sd1073741823;
	localparam logic signed [33:0] CELL_MIN = -34'sd1073741824;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_RESET  = 1'b1
	} req_t;

	// One ELF/PJW-style step over one byte; the high nibble is folded back in at bit 5, not bit 4.
	function automatic logic [KEY_W-1:0] elf_step(input logic [KEY_W-1:0] h,
		input logic [7:0] b);
		logic [31:0] t;
		t = {h, 4'b0000} + {24'd0, b};
		t = t ^ {23'd0, t[31:28], 5'd0};
		return t[KEY_W-1:0];
	endfunction
endpackage

/* rtl/core/schr_div.sv */
`timescale 1ns / 1ps
// Restoring divider: unsigned 33-bit magnitude by 31-bit divisor, one bit a cycle.
module schr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [32:0] quotient
);
	logic [32:0] quo_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[32]} - {2'b00, divisor};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				quo_q  <= dividend;
				rem_q  <= '0;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[32]};
					quo_q <= {quo_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

/* rtl/core/spatial_cell_hash_registry_top.sv */
`timescale 1ns / 1ps
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | req_type, coord_x, coord_y, coord_z
// out     | out_valid / out_ready  | entry_index, cell_x..z, is_new, status
// cfg     | cfg_valid / cfg_ready  | cfg_data (half_width)
//
// A lookup runs three divisions on the shared divider (start, a step per quotient
// bit, done), hashes the 12 bytes of the three cells, makes one recent-key check,
// then reads and compares each entry in the key search (a miss on a full table of
// 256 scans all of them). A reset request is answered straight from the idle state.
// The stores need no clearing pass after arst_n: the fill count marks which entries
// hold data. Input is not taken while a result beat waits on out_ready.
module spatial_cell_hash_registry_top #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  entry_index,
	output logic signed [30:0] cell_x,
	output logic signed [30:0] cell_y,
	output logic signed [30:0] cell_z,
	output logic        is_new,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [28:0] cfg_data
);
	localparam int unsigned IW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_HASH, ST_RECENT, ST_RD,
		ST_CMP, ST_FETCH, ST_FETCH2, ST_OUT
	} state_t;

	state_t state_q;
	logic [28:0] hw_q;
	logic [1:0]  axis_q;
	logic signed [31:0] crd_q [3];
	logic signed [30:0] cel_q [3];
	logic [3:0]  byte_q;
	logic [27:0] key_q;
	logic [CW-1:0] count_q;
	logic [27:0] recent_key_q;
	logic [IW-1:0] recent_idx_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] scan_q;

	logic [27:0] key_mem [TABLE_DEPTH];
	logic [30:0] cx_mem [TABLE_DEPTH];
	logic [30:0] cy_mem [TABLE_DEPTH];
	logic [30:0] cz_mem [TABLE_DEPTH];
	logic [27:0] key_rd_q;
	logic [30:0] cx_rd_q, cy_rd_q, cz_rd_q;
	logic [IW-1:0] rd_addr;

	// Divider feed: |v| + hw, sign kept aside; quotient truncates toward zero.
	logic signed [31:0] cur;
	logic        neg;
	logic [32:0] mag, dvd;
	logic [28:0] hw_eff;
	logic        div_start, div_done;
	logic [32:0] div_q;
	logic signed [33:0] q_s;
	logic signed [30:0] q_sat;
	logic [31:0] hword;
	logic [7:0]  hbyte;

	assign cur    = crd_q[axis_q];
	assign neg    = !(cur > 32'sd0);
	assign mag    = neg ? (33'd0 - {cur[31], cur}) : {1'b0, cur};
	assign hw_eff = (hw_q == '0) ? 29'd1 : hw_q;
	assign dvd    = mag + {4'd0, hw_eff};
	assign div_start = (state_q == ST_DIV_GO);

	schr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd),
		.divisor({1'b0, hw_eff, 1'b0}), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		q_s = neg ? (34'sd0 - $signed({1'b0, div_q})) : $signed({1'b0, div_q});
		if (q_s > schr_pkg::CELL_MAX) q_sat = 31'sh3fffffff;
		else if (q_s < schr_pkg::CELL_MIN) q_sat = 31'sh40000000;
		else q_sat = q_s[30:0];
	end

	assign hword = {{1{cel_q[byte_q[3:2]][30]}}, cel_q[byte_q[3:2]]};
	assign hbyte = hword[8*byte_q[1:0] +: 8];

	assign rd_addr = (state_q == ST_CMP || state_q == ST_FETCH) ? idx_q : scan_q[IW-1:0];

	assign in_ready  = (state_q == ST_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hw_q <= schr_pkg::HW_RESET;
		else if (cfg_valid) hw_q <= cfg_data;
	end

	logic mem_we;
	logic [IW-1:0] mem_wa;
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa] <= key_q;
			cx_mem[mem_wa]  <= cel_q[0];
			cy_mem[mem_wa]  <= cel_q[1];
			cz_mem[mem_wa]  <= cel_q[2];
		end
		key_rd_q <= key_mem[rd_addr];
		cx_rd_q  <= cx_mem[rd_addr];
		cy_rd_q  <= cy_mem[rd_addr];
		cz_rd_q  <= cz_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			count_q <= CW'(1);
			recent_key_q <= '0;
			recent_idx_q <= '0;
			axis_q <= '0; byte_q <= '0; key_q <= '0; idx_q <= '0; scan_q <= '0;
			entry_index <= '0; cell_x <= '0; cell_y <= '0; cell_z <= '0;
			is_new <= 1'b0; status <= 1'b0;
			mem_we <= 1'b1; mem_wa <= '0;
			crd_q <= '{default: '0}; cel_q <= '{default: '0};
		end else begin
			mem_we <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (req_type == schr_pkg::REQ_RESET) begin
							count_q <= CW'(1);
							recent_key_q <= '0; recent_idx_q <= '0;
							cel_q <= '{default: '0}; key_q <= '0;
							mem_we <= 1'b1; mem_wa <= '0;
							entry_index <= '0; cell_x <= '0; cell_y <= '0; cell_z <= '0;
							is_new <= 1'b0; status <= 1'b0; out_valid <= 1'b1;
						end else begin
							crd_q[0] <= coord_x; crd_q[1] <= coord_y; crd_q[2] <= coord_z;
							axis_q <= '0;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						cel_q[axis_q] <= q_sat;
						if (axis_q == 2'd2) begin
							byte_q <= '0; key_q <= '0; state_q <= ST_HASH;
						end else begin
							axis_q <= axis_q + 2'd1; state_q <= ST_DIV_GO;
						end
					end
				end
				ST_HASH: begin
					key_q <= schr_pkg::elf_step(key_q, hbyte);
					byte_q <= byte_q + 4'd1;
					if (byte_q == 4'd11) state_q <= ST_RECENT;
				end
				ST_RECENT: begin
					if (key_q == recent_key_q) begin
						idx_q <= recent_idx_q; state_q <= ST_FETCH; is_new <= 1'b0;
					end else begin
						scan_q <= '0; state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// Read issued at scan_q; compare next cycle.
					idx_q <= scan_q[IW-1:0];
					if (scan_q >= count_q) begin
						if (count_q >= CW'(TABLE_DEPTH)) begin
							entry_index <= '0; cell_x <= '0; cell_y <= '0; cell_z <= '0;
							is_new <= 1'b0; status <= 1'b1; out_valid <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							mem_we <= 1'b1; mem_wa <= count_q[IW-1:0];
							count_q <= count_q + CW'(1);
							recent_key_q <= key_q; recent_idx_q <= count_q[IW-1:0];
							entry_index <= 8'(count_q); cell_x <= cel_q[0];
							cell_y <= cel_q[1]; cell_z <= cel_q[2];
							is_new <= 1'b1; status <= 1'b0; out_valid <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (key_rd_q == key_q) begin
						recent_key_q <= key_q; recent_idx_q <= idx_q;
						is_new <= 1'b0; state_q <= ST_FETCH;
					end else begin
						scan_q <= scan_q + CW'(1); state_q <= ST_RD;
					end
				end
				ST_FETCH: state_q <= ST_FETCH2;
				ST_FETCH2: begin
					entry_index <= 8'(idx_q);
					cell_x <= cx_rd_q; cell_y <= cy_rd_q; cell_z <= cz_rd_q;
					status <= 1'b0; out_valid <= 1'b1; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE)) else $error("ready outside idle");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= CW'(TABLE_DEPTH))) else $error("count range");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> !is_new) else $error("full and new");
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the grid-cell hash registry.
// Lookup and table-reset beats are driven on the input channel while a local
// model of the table predicts every result beat. A checker process compares each
// accepted result beat with the oldest prediction, field by field.
// The configured half width is changed only while the block is idle.
module tb_top;
	// Prediction record for one result beat.
	typedef struct packed {
		logic [7:0] idx;
		logic signed [30:0] cx;
		logic signed [30:0] cy;
		logic signed [30:0] cz;
		logic fresh;
		logic full;
	} cell_result_t;

	localparam int DEPTH = 256;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic req_type;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic out_valid, out_ready;
	logic [7:0] entry_index;
	logic signed [30:0] cell_x, cell_y, cell_z;
	logic is_new, status;
	logic cfg_valid, cfg_ready;
	logic [28:0] cfg_data;

	// Local copy of the registry, kept in step with the block.
	logic [28:0] hw_model;
	logic [27:0] key_tab [DEPTH];
	logic signed [30:0] cx_tab [DEPTH], cy_tab [DEPTH], cz_tab [DEPTH];
	int fill;
	logic [27:0] last_key;
	int last_idx;

	cell_result_t pending_results[$];
	int errors;
	int beats_in, beats_out, n_new, n_full, n_clear;
	int idle_cycles = 0;
	bit hold_off;       // Forces out_ready low for a long stretch.
	bit sink_random;    // Enables random stalls on the result side.

	spatial_cell_hash_registry_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_index(entry_index), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
		.is_new(is_new), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Turns a coordinate into a saturated cell index, truncating toward zero.
	function automatic logic signed [30:0] cell_of(logic signed [31:0] v, logic [28:0] hw);
		longint h, n, q;
		h = (hw == 0) ? 1 : longint'(hw);
		n = (v > 0) ? longint'(v) + h : longint'(v) - h;
		q = n / (2 * h);
		if (q > 64'sd1073741823) q = 64'sd1073741823;
		if (q < -64'sd1073741824) q = -64'sd1073741824;
		return q[30:0];
	endfunction

	// Folds the four little-endian bytes of a sign-extended cell into the key.
	function automatic logic [27:0] fold_cell(logic [27:0] h, logic signed [30:0] c);
		logic [31:0] w, t;
		w = {c[30], c};
		t = {4'd0, h};
		for (int b = 0; b < 4; b++) begin
			t = (t << 4) + {24'd0, w[8*b +: 8]};
			t = t ^ ((t & 32'hf000_0000) >> 23);
			t = t & 32'h0fff_ffff;
		end
		return t[27:0];
	endfunction

	function automatic cell_result_t entry_result(int i, bit fresh);
		cell_result_t r;
		r.idx = i[7:0];
		r.cx = cx_tab[i];
		r.cy = cy_tab[i];
		r.cz = cz_tab[i];
		r.fresh = fresh;
		r.full = 1'b0;
		return r;
	endfunction

	function automatic void clear_registry();
		fill = 1;
		last_key = '0;
		last_idx = 0;
		key_tab[0] = '0;
		cx_tab[0] = '0;
		cy_tab[0] = '0;
		cz_tab[0] = '0;
	endfunction

	// Applies one request to the local registry and returns the result it must produce.
	function automatic cell_result_t registry_step(schr_pkg::req_t kind,
		logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		cell_result_t r;
		logic signed [30:0] a, b, c;
		logic [27:0] k;
		r = '0;
		if (kind == schr_pkg::REQ_RESET) begin
			clear_registry();
			n_clear++;
			return r;
		end
		a = cell_of(x, hw_model);
		b = cell_of(y, hw_model);
		c = cell_of(z, hw_model);
		k = fold_cell(fold_cell(fold_cell('0, a), b), c);
		if (k == last_key)
			return entry_result(last_idx, 1'b0);
		for (int i = 0; i < fill; i++) begin
			if (key_tab[i] == k) begin
				last_key = k;
				last_idx = i;
				return entry_result(i, 1'b0);
			end
		end
		if (fill >= DEPTH) begin
			r.full = 1'b1;
			n_full++;
			return r;
		end
		key_tab[fill] = k;
		cx_tab[fill] = a;
		cy_tab[fill] = b;
		cz_tab[fill] = c;
		last_key = k;
		last_idx = fill;
		fill++;
		n_new++;
		return entry_result(fill - 1, 1'b1);
	endfunction

	// Sends one request beat; the prediction is queued when the beat is accepted.
	// Before valid rises the bench waits on the falling clock, sometimes for a random gap
	// when gaps are allowed, so valid from the previous beat is always seen low first.
	task automatic send_request(schr_pkg::req_t kind, logic signed [31:0] x,
		logic signed [31:0] y, logic signed [31:0] z, bit allow_gap = 1);
		int gap;
		gap = 1;
		if (allow_gap && $urandom_range(0, 2) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
		repeat (gap) @(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.insert(pending_results.size(), registry_step(kind, x, y, z));
		beats_in++;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) @(negedge clk);
		// A result beat is always expected; after the last one the block is still left idle before returning.
		repeat (20) @(negedge clk);
	endtask

	// Writes half_width; only called with nothing outstanding.
	task automatic write_half_width(logic [28:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		hw_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Builds a coordinate in or near cell c for the current half width.
	function automatic logic signed [31:0] point_in_cell(int c);
		longint h, v;
		h = (hw_model == 0) ? 1 : longint'(hw_model);
		v = 2 * h * c + ((c >= 0) ? 0 : 0);
		v = v + longint'($urandom_range(0, 7)) - 3;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] any_coord();
		return $urandom();
	endfunction

	// Field extremes, both request kinds, zero width and saturation.
	task automatic test_directed();
		send_request(schr_pkg::REQ_LOOKUP, 0, 0, 0);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_request(schr_pkg::REQ_LOOKUP, -1, 1, 32'sh55555555);
		send_request(schr_pkg::REQ_LOOKUP, 32'shaaaaaaaa, 32'sh55555555, -1);
		send_request(schr_pkg::REQ_RESET, 32'sh12345678, -5, 7);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		// Zero half width behaves as one, which drives cells into saturation.
		write_half_width(29'd0);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh7fffffff, 32'sh80000000, 3);
		send_request(schr_pkg::REQ_LOOKUP, -3, 2, 0);
		write_half_width(29'd1);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh7fffffff, 32'sh80000000, 3);
		send_request(schr_pkg::REQ_LOOKUP, 1, -1, 2);
		write_half_width(29'h1fffffff);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh7fffffff, 32'sh80000000, 0);
		send_request(schr_pkg::REQ_LOOKUP, 32'sh20000000, -32'sh20000000, 1);
		send_request(schr_pkg::REQ_RESET, 0, 0, 0);
		write_half_width(schr_pkg::HW_RESET);
	endtask

	// Fills the table to capacity with a small width, then probes the full state.
	task automatic test_table_full();
		write_half_width(29'd1);
		send_request(schr_pkg::REQ_RESET, 0, 0, 0);
		for (int i = 0; i < 300; i++)
			send_request(schr_pkg::REQ_LOOKUP, 2 * i + 1, -2 * i, 32'(i * 7), 0);
		for (int i = 0; i < 20; i++)
			send_request(schr_pkg::REQ_LOOKUP, any_coord(), any_coord(), any_coord());
		send_request(schr_pkg::REQ_LOOKUP, 3, -2, 7);
		send_request(schr_pkg::REQ_RESET, 0, 0, 0);
	endtask

	// Mostly points clustered in a few cells, so hits, repeats and appends all occur.
	task automatic test_random_lookups(int count);
		int c;
		for (int i = 0; i < count; i++) begin
			if (i % 300 == 299) begin
				case ($urandom_range(0, 3))
				0: write_half_width(29'($urandom_range(1, 16)));
				1: write_half_width(29'($urandom()) & 29'h1fffffff);
				2: write_half_width(29'($urandom_range(100, 300000)));
				default: write_half_width(schr_pkg::HW_RESET);
				endcase
			end
			c = $urandom_range(0, 9);
			if (c == 0)
				send_request(schr_pkg::REQ_LOOKUP, any_coord(), any_coord(), any_coord());
			else if (c == 1 && $urandom_range(0, 9) == 0)
				send_request(schr_pkg::REQ_RESET, any_coord(), any_coord(), any_coord());
			else
				send_request(schr_pkg::REQ_LOOKUP, point_in_cell($urandom_range(0, 12) - 6),
					point_in_cell($urandom_range(0, 8) - 4),
					point_in_cell($urandom_range(0, 4) - 2), $urandom_range(0, 3) != 0);
		end
	endtask

	// The result side stalls for a long stretch while requests keep coming.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_request(schr_pkg::REQ_LOOKUP, point_in_cell(i), point_in_cell(-i), 0, 0);
		join
		drain_results();
	endtask

	// Result-side handshake: random stalls, mostly short, a few long.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ready <= 1'b0;
			else if (sink_random && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
				repeat (stall - 1) @(negedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	// Checks every accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: idx %0d", $time, entry_index);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (entry_index !== want.idx) begin
					$display("%0t: entry_index expected %0d actual %0d", $time, want.idx, entry_index);
					errors++;
				end
				if (cell_x !== want.cx) begin
					$display("%0t: cell_x expected %0d actual %0d", $time, want.cx, cell_x);
					errors++;
				end
				if (cell_y !== want.cy) begin
					$display("%0t: cell_y expected %0d actual %0d", $time, want.cy, cell_y);
					errors++;
				end
				if (cell_z !== want.cz) begin
					$display("%0t: cell_z expected %0d actual %0d", $time, want.cz, cell_z);
					errors++;
				end
				if (is_new !== want.fresh) begin
					$display("%0t: is_new expected %0b actual %0b", $time, want.fresh, is_new);
					errors++;
				end
				if (status !== want.full) begin
					$display("%0t: status expected %0b actual %0b", $time, want.full, status);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run when no beat is accepted for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
			|| !arst_n || (!in_valid && pending_results.size() == 0))
			idle_cycles <= 0;
		else if (!hold_off)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_results.size());
			$display("spatial_cell_hash_registry_top regression: fail");
			$finish;
		end
	end

	initial begin
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		n_new = 0;
		n_full = 0;
		n_clear = 0;
		hold_off = 1'b0;
		sink_random = 1'b0;
		in_valid = 1'b0;
		req_type = schr_pkg::REQ_LOOKUP;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hw_model = schr_pkg::HW_RESET;
		clear_registry();
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		sink_random = 1'b1;
		test_backpressure();
		test_table_full();
		test_random_lookups(1400);
		write_half_width(29'd5);
		drain_results();

		$display("covered %0d request beats and %0d result beats: %0d appends, %0d table-full",
			beats_in, beats_out, n_new, n_full);
		$display("results, %0d table resets, width changes including 0, 1 and the maximum", n_clear);
		if (errors == 0)
			$display("spatial_cell_hash_registry_top regression: pass");
		else
			$display("spatial_cell_hash_registry_top regression: fail");
		$finish;
	end
endmodule

/* files.f */
rtl/core/schr_pkg.sv
rtl/core/schr_div.sv
rtl/core/spatial_cell_hash_registry_top.sv
dv/tb_top.sv
